[rtl/contiguous_fit_allocator_defines.svh]
// Assertion macros used by the contiguous fit allocator RTL.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFA_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFA_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfa assertion failed");

`endif

[rtl/cfa_pkg.sv]
// Package for the contiguous fit allocator: sizes, codes and payload types.
// No dependencies; used by cfa_cell and contiguous_fit_allocator.
`timescale 1ns / 1ps
package cfa_pkg;

	localparam int MEM_SIZE = 1024;
	localparam int MAX_SEGS = 16;
	localparam int IDX_W    = $clog2(MAX_SEGS);
	localparam int COUNT_W  = $clog2(MAX_SEGS + 1);
	localparam int SIZE_W   = 11;
	localparam int OWNER_W  = 6;
	localparam int LT_W     = SIZE_W + 1;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_CLOSE = 2'd1,
		OP_END   = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FRAG  = 2'd1,
		ST_NOMEM = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_SCAN,
		CTL_REPLY
	} ctl_state_t;

	// Request payload
	typedef struct packed {
		op_t                 operation;
		logic [SIZE_W-1:0]   size_value;
		logic [OWNER_W-1:0]  process_id;
	} req_t;

	// Result payload
	typedef struct packed {
		status_t             status;
		logic [3:0]          first_fit_index;
		logic [3:0]          best_fit_index;
		logic [3:0]          worst_fit_index;
		logic [SIZE_W-1:0]   total_free;
	} res_t;

	// One segment entry held by a cell
	typedef struct packed {
		logic [SIZE_W-1:0]   size;
		logic                free;
		logic [OWNER_W-1:0]  owner;
	} entry_t;

	// Scan record that walks down the cell chain
	typedef struct packed {
		logic                valid;
		op_t                 op;
		logic [SIZE_W-1:0]   size;
		logic [OWNER_W-1:0]  owner;
		logic [IDX_W-1:0]    pos;
		logic                matched;
		logic                found;
		logic [SIZE_W-1:0]   total;
		logic [IDX_W-1:0]    ff;
		logic [IDX_W-1:0]    bf;
		logic [IDX_W-1:0]    wf;
		logic [SIZE_W-1:0]   best;
		logic [SIZE_W-1:0]   worst;
	} scan_t;

endpackage

[rtl/cfa_cell.sv]
// One segment cell of the allocator chain: holds one table entry and
// processes the passing scan record. Depends on cfa_pkg.
`timescale 1ns / 1ps
module cfa_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfa_pkg::scan_t          rec_in,
	input  logic [cfa_pkg::COUNT_W-1:0] seg_count,
	input  logic                    wr_en,
	input  cfa_pkg::entry_t         wr_data,
	output cfa_pkg::scan_t          rec_out
);
	import cfa_pkg::*;

	entry_t            ent_q;
	scan_t             rec_q;
	scan_t             rec_d;
	logic              live;
	logic              do_free;
	logic [SIZE_W:0]   sum;

	// Record step through this cell
	always_comb begin
		rec_d   = rec_in;
		do_free = 1'b0;
		live    = rec_in.valid && ({1'b0, rec_in.pos} < seg_count);
		sum     = {1'b0, rec_in.total} + {1'b0, ent_q.size};
		rec_d.pos = rec_in.pos + 1'b1;
		if (live) begin
			if (rec_in.op == OP_END) begin
				if (!rec_in.matched && ent_q.owner == rec_in.owner) begin
					rec_d.matched = 1'b1;
					do_free       = 1'b1;
				end
			end else if (ent_q.free) begin
				// saturating free total
				rec_d.total = sum[SIZE_W] ? {SIZE_W{1'b1}} : sum[SIZE_W-1:0];
				if (rec_in.size <= ent_q.size) begin
					if (!rec_in.found) begin
						rec_d.found = 1'b1;
						rec_d.ff    = rec_in.pos;
						rec_d.bf    = rec_in.pos;
						rec_d.wf    = rec_in.pos;
						rec_d.best  = ent_q.size;
						rec_d.worst = ent_q.size;
					end else begin
						if (ent_q.size < rec_in.best) begin
							rec_d.best = ent_q.size;
							rec_d.bf   = rec_in.pos;
						end
						if (ent_q.size > rec_in.worst) begin
							rec_d.worst = ent_q.size;
							rec_d.wf    = rec_in.pos;
						end
					end
				end
			end
		end
	end

	// Record register toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= rec_d;
		end
	end

	// Entry storage: append write or release
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q <= wr_data;
		end else if (do_free) begin
			ent_q.free  <= 1'b1;
			ent_q.owner <= '0;
		end
	end

	assign rec_out = rec_q;

endmodule

[rtl/contiguous_fit_allocator.sv]
// Contiguous fit allocator: a load or close raises done in the cycle after accept.
// An end or place query walks a chain of 16 segment cells, one cell per cycle;
// done follows through the control state register once the record leaves the last cell.
// busy is low in the done cycle, so a new request may be taken there.
// arst_n clears the segment count, the loaded total, the control state and the cell
// record registers; segment entries hold no reset and are only read below the segment count.
`timescale 1ns / 1ps
`include "contiguous_fit_allocator_defines.svh"
module contiguous_fit_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  cfa_pkg::req_t  request,
	output logic           done,
	output cfa_pkg::res_t  result
);
	import cfa_pkg::*;

	ctl_state_t            state_q;
	ctl_state_t            state_d;
	logic [COUNT_W-1:0]    seg_count_q;
	logic [LT_W-1:0]       load_total_q;
	res_t                  res_q;
	res_t                  res_d;
	logic                  res_ld;
	logic                  accept;
	logic                  is_append;
	logic                  accept_app;
	logic                  tbl_full;
	logic                  lt_full;
	logic                  app_ok;
	logic                  wr_en;
	logic [LT_W-1:0]       lt_sum;
	logic [LT_W-1:0]       lt_rem;
	entry_t                wr_data;
	logic [MAX_SEGS-1:0]   wr_sel;
	logic [MAX_SEGS-1:0]   chain_valid;
	scan_t                 link [MAX_SEGS+1];
	scan_t                 tail;
	logic                  tail_valid;

	assign accept     = start && !busy;
	assign is_append  = (request.operation == OP_LOAD) || (request.operation == OP_CLOSE);
	assign accept_app = accept && is_append;
	assign tail       = link[MAX_SEGS];
	assign tail_valid = tail.valid;

	// Append checks and write data
	always_comb begin
		tbl_full = seg_count_q >= COUNT_W'(MAX_SEGS);
		lt_full  = load_total_q >= LT_W'(MEM_SIZE);
		lt_sum   = load_total_q + {1'b0, request.size_value};
		lt_rem   = LT_W'(MEM_SIZE) - load_total_q;
		app_ok   = (request.operation == OP_LOAD) ? !tbl_full : (!tbl_full && !lt_full);
		wr_en    = accept_app && app_ok;
		if (request.operation == OP_LOAD) begin
			wr_data.size  = request.size_value;
			wr_data.free  = (request.process_id == '0);
			wr_data.owner = request.process_id;
		end else begin
			wr_data.size  = lt_rem[SIZE_W-1:0];
			wr_data.free  = 1'b1;
			wr_data.owner = '0;
		end
		for (int i = 0; i < MAX_SEGS; i++) begin
			wr_sel[i] = wr_en && (seg_count_q[IDX_W-1:0] == IDX_W'(i));
		end
	end

	// Table count and loaded total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q  <= '0;
			load_total_q <= '0;
		end else if (wr_en) begin
			seg_count_q <= seg_count_q + 1'b1;
			if (request.operation == OP_LOAD && request.process_id != '0) begin
				load_total_q <= (lt_sum > LT_W'(MEM_SIZE)) ? LT_W'(MEM_SIZE) : lt_sum;
			end
		end
	end

	// Record injected at the head of the chain
	always_comb begin
		link[0]       = '0;
		link[0].valid = accept && !is_append;
		link[0].op    = request.operation;
		link[0].size  = request.size_value;
		link[0].owner = request.process_id;
	end

	// Cell chain
	for (genvar g = 0; g < MAX_SEGS; g++) begin : g_cell
		cfa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.rec_in    (link[g]),
			.seg_count (seg_count_q),
			.wr_en     (wr_sel[g]),
			.wr_data   (wr_data),
			.rec_out   (link[g+1])
		);
		assign chain_valid[g] = link[g+1].valid;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CTL_IDLE, CTL_REPLY: begin
				if (accept) begin
					state_d = is_append ? CTL_REPLY : CTL_SCAN;
				end else begin
					state_d = CTL_IDLE;
				end
			end
			CTL_SCAN: begin
				if (tail_valid) begin
					state_d = CTL_REPLY;
				end
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		busy = 1'b0;
		done = 1'b0;
		case (state_q)
			CTL_SCAN:  busy = 1'b1;
			CTL_REPLY: done = 1'b1;
			default:   busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result formation
	always_comb begin
		res_d  = '0;
		res_ld = 1'b0;
		if (accept_app) begin
			res_ld       = 1'b1;
			res_d.status = app_ok ? ST_OK : ST_FULL;
		end else if (tail_valid) begin
			res_ld = 1'b1;
			if (tail.op == OP_QUERY) begin
				res_d.first_fit_index = 4'(tail.ff);
				res_d.best_fit_index  = 4'(tail.bf);
				res_d.worst_fit_index = 4'(tail.wf);
				res_d.total_free      = tail.total;
				if (tail.found) begin
					res_d.status = ST_OK;
				end else if (tail.size <= tail.total) begin
					res_d.status = ST_FRAG;
				end else begin
					res_d.status = ST_NOMEM;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

	`CFA_ASSERT_IMP(a_done_src, done, $past(tail_valid) || $past(accept_app))
	`CFA_ASSERT_NXT(a_scan_hold, busy && !tail_valid, busy)
	`CFA_ASSERT_IMP(a_one_rec, 1'b1, $onehot0(chain_valid))
	`CFA_ASSERT_IMP(a_count_bound, 1'b1, seg_count_q <= COUNT_W'(MAX_SEGS))
	`CFA_ASSERT_IMP(a_total_bound, 1'b1, load_total_q <= LT_W'(MEM_SIZE))

endmodule
